// ===== sv/ctlps_pkg.sv =====
// Shared types, constants and the number parser step for the pan/tilt line unit.
package ctlps_pkg;

   localparam int LINE_DEPTH_DEFAULT = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_CENTER     = 3'd0,
      CSR_Y_CENTER     = 3'd1,
      CSR_DEAD_BAND    = 3'd2,
      CSR_X_GAIN       = 3'd3,
      CSR_Y_GAIN       = 3'd4,
      CSR_X_STEP_LIMIT = 3'd5,
      CSR_Y_STEP_LIMIT = 3'd6
   } csr_index_type;

   localparam logic [15:0] X_CENTER_RESET     = 16'd160;
   localparam logic [15:0] Y_CENTER_RESET     = 16'd112;
   localparam logic [15:0] DEAD_BAND_RESET    = 16'd15;
   localparam logic [11:0] X_GAIN_RESET       = 12'd192;
   localparam logic [11:0] Y_GAIN_RESET       = 12'd128;
   localparam logic [15:0] X_STEP_LIMIT_RESET = 16'd1200;
   localparam logic [15:0] Y_STEP_LIMIT_RESET = 16'd800;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_Y     = 8'h59;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_STOP   = 3'b100
   } num_phase_type;

   typedef struct packed {
      num_phase_type phase;
      logic          negative;
      logic [15:0]   value;
   } num_type;

   localparam num_type NUM_CLEAR = '{phase: PH_SKIP, negative: 1'b0, value: 16'd0};

   typedef struct packed {
      logic [15:0] center;
      logic [15:0] dead_band;
      logic [11:0] gain;
      logic [15:0] limit;
   } axis_cfg_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] x_target;
      logic [15:0] y_target;
   } line_type;

   // One byte of an atoi style scan: blanks, an optional sign, then digits.
   function automatic num_type num_feed(num_type p, logic [7:0] c);
      num_type n;
      logic    blank;
      logic    digit;
      logic    sign;
      n     = p;
      blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
              (c == CHAR_LF) || (c == CHAR_CR);
      digit = c inside {[8'h30:8'h39]};
      sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      if (p.phase != PH_STOP) begin
         if (digit) begin
            n.value = {p.value[12:0], 3'b000} + {p.value[14:0], 1'b0} +
                      {12'd0, c[3:0]};
            n.phase = PH_DIGITS;
         end else if (p.phase == PH_SKIP && sign) begin
            n.negative = (c == CHAR_MINUS);
            n.phase    = PH_DIGITS;
         end else if (!(p.phase == PH_SKIP && blank)) begin
            n.phase = PH_STOP;
         end
      end
      return n;
   endfunction

endpackage

// ===== sv/coordinate_line_to_pan_tilt_steps_unit.sv =====
// Top level of the serial coordinate line to pan/tilt step command unit.
// Takes one received byte per clock and builds lines of the form X<num>Y<num> ended by a
// newline; carriage returns are ignored and only the first LINE_DEPTH-1 stored bytes count.
// Bytes are accepted back to back, so the sustained rate is one item per clock; the only
// thing that holds the input is a full result pipeline under output stall. A newline that
// ends a valid line with a nonzero step count on either axis yields one result: the edge
// that accepts the newline loads the target register, and the error subtract, the
// magnitude and dead band stage, the gain multiply stage and the clamped output register
// follow in that order. Configuration is written through csr_write, csr_index and
// csr_data; the user must write it only while no line is in flight, as the block does
// not enforce this; gains take the low 12 bits of the data.
module coordinate_line_to_pan_tilt_steps_unit import ctlps_pkg::*; #(
   parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_x_steps,
   output logic                   rsp_x_direction,
   output logic [15:0]            rsp_y_steps,
   output logic                   rsp_y_direction,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [15:0] x_center_ff, y_center_ff, dead_band_ff;
   logic [11:0] x_gain_ff, y_gain_ff;
   logic [15:0] x_limit_ff, y_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_center_ff  <= X_CENTER_RESET;
         y_center_ff  <= Y_CENTER_RESET;
         dead_band_ff <= DEAD_BAND_RESET;
         x_gain_ff    <= X_GAIN_RESET;
         y_gain_ff    <= Y_GAIN_RESET;
         x_limit_ff   <= X_STEP_LIMIT_RESET;
         y_limit_ff   <= Y_STEP_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_CENTER:     x_center_ff  <= csr_data;
            CSR_Y_CENTER:     y_center_ff  <= csr_data;
            CSR_DEAD_BAND:    dead_band_ff <= csr_data;
            CSR_X_GAIN:       x_gain_ff    <= csr_data[11:0];
            CSR_Y_GAIN:       y_gain_ff    <= csr_data[11:0];
            CSR_X_STEP_LIMIT: x_limit_ff   <= csr_data;
            CSR_Y_STEP_LIMIT: y_limit_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   axis_cfg_type x_cfg, y_cfg;
   assign x_cfg = '{center: x_center_ff, dead_band: dead_band_ff, gain: x_gain_ff,
                    limit: x_limit_ff};
   assign y_cfg = '{center: y_center_ff, dead_band: dead_band_ff, gain: y_gain_ff,
                    limit: y_limit_ff};

   // Pipeline occupancy. A stage may load when it is empty or its contents move on.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic out_free, s4_free, s3_free, s2_free, s1_free;
   logic accept;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign s4_free   = !s4_valid_ff || out_free;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;

   line_type line;

   ctlps_parse #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .rx_data(req_rx_data),
      .line   (line)
   );

   logic [15:0] x_target_ff, y_target_ff;

   always_ff @(posedge clock) begin
      if (s1_free) begin
         x_target_ff <= line.x_target;
         y_target_ff <= line.y_target;
      end
   end

   logic [15:0] x_steps, y_steps;
   logic        x_dir, y_dir;

   ctlps_axis u_axis_x (
      .clock    (clock),
      .cfg      (x_cfg),
      .target   (x_target_ff),
      .load_err (s2_free),
      .load_mag (s3_free),
      .load_prod(s4_free),
      .steps    (x_steps),
      .direction(x_dir)
   );

   ctlps_axis u_axis_y (
      .clock    (clock),
      .cfg      (y_cfg),
      .target   (y_target_ff),
      .load_err (s2_free),
      .load_mag (s3_free),
      .load_prod(s4_free),
      .steps    (y_steps),
      .direction(y_dir)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= line.valid;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
         if (s3_free) s3_valid_ff <= s2_valid_ff;
         if (s4_free) s4_valid_ff <= s3_valid_ff;
         // A line that moves neither axis is dropped here.
         if (out_free) rsp_valid <= s4_valid_ff && ((x_steps | y_steps) != 16'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_x_steps     <= x_steps;
         rsp_x_direction <= x_dir;
         rsp_y_steps     <= y_steps;
         rsp_y_direction <= y_dir;
      end
   end

endmodule

// ===== sv/ctlps_parse.sv =====
// Line assembler: tracks one coordinate line byte by byte and reports a valid line at its newline.
module ctlps_parse import ctlps_pkg::*; #(
   parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_data,
   output line_type   line
);

   localparam int COUNT_W = $clog2(LINE_DEPTH);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(LINE_DEPTH - 1);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               starts_x_ff, starts_x_in;
   logic               y_seen_ff, y_seen_in;
   logic               zero_ff, zero_in;
   num_type            xnum_ff, xnum_in;
   num_type            ynum_ff, ynum_in;

   always_comb begin
      count_in    = count_ff;
      starts_x_in = starts_x_ff;
      y_seen_in   = y_seen_ff;
      zero_in     = zero_ff;
      xnum_in     = xnum_ff;
      ynum_in     = ynum_ff;
      if (accept) begin
         if (rx_data == CHAR_LF) begin
            count_in    = '0;
            starts_x_in = 1'b0;
            y_seen_in   = 1'b0;
            zero_in     = 1'b0;
            xnum_in     = NUM_CLEAR;
            ynum_in     = NUM_CLEAR;
         end else if (rx_data != CHAR_CR && count_ff != COUNT_LAST) begin
            count_in = count_ff + 1'b1;
            // Bytes after a zero byte still take a slot but are not looked at.
            if (!zero_ff) begin
               if (rx_data == CHAR_NUL) begin
                  zero_in = 1'b1;
               end else if (count_ff == '0) begin
                  starts_x_in = (rx_data == CHAR_X);
               end else if (!y_seen_ff) begin
                  if (rx_data == CHAR_Y) begin
                     y_seen_in = 1'b1;
                  end else begin
                     xnum_in = num_feed(xnum_ff, rx_data);
                  end
               end else begin
                  ynum_in = num_feed(ynum_ff, rx_data);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         starts_x_ff <= 1'b0;
         y_seen_ff   <= 1'b0;
         zero_ff     <= 1'b0;
         xnum_ff     <= NUM_CLEAR;
         ynum_ff     <= NUM_CLEAR;
      end else begin
         count_ff    <= count_in;
         starts_x_ff <= starts_x_in;
         y_seen_ff   <= y_seen_in;
         zero_ff     <= zero_in;
         xnum_ff     <= xnum_in;
         ynum_ff     <= ynum_in;
      end
   end

   assign line.valid    = accept && (rx_data == CHAR_LF) && starts_x_ff && y_seen_ff;
   assign line.x_target = xnum_ff.negative ? (16'd0 - xnum_ff.value) : xnum_ff.value;
   assign line.y_target = ynum_ff.negative ? (16'd0 - ynum_ff.value) : ynum_ff.value;

endmodule

// ===== sv/ctlps_axis.sv =====
// One axis: error against center, dead band test, gain multiply and step clamp over three stages.
module ctlps_axis import ctlps_pkg::*; (
   input  logic         clock,
   input  axis_cfg_type cfg,
   input  logic [15:0]  target,
   input  logic         load_err,
   input  logic         load_mag,
   input  logic         load_prod,
   output logic [15:0]  steps,
   output logic         direction
);

   logic [15:0] err_ff;
   logic [16:0] mag_ff;
   logic        move_ff;
   logic        dir_ff;
   logic [28:0] prod_ff;
   logic        move_p_ff;
   logic        dir_p_ff;

   logic [16:0] mag_in;
   logic [24:0] scaled;

   // Magnitude of a 16-bit two's complement error, 0 to 32768.
   assign mag_in = err_ff[15] ? (17'h10000 - {1'b0, err_ff}) : {1'b0, err_ff};

   always_ff @(posedge clock) begin
      if (load_err) begin
         err_ff <= target - cfg.center;
      end
      if (load_mag) begin
         mag_ff  <= mag_in;
         move_ff <= (mag_in > {1'b0, cfg.dead_band});
         dir_ff  <= !err_ff[15] && (err_ff != 16'd0);
      end
      if (load_prod) begin
         prod_ff   <= mag_ff * cfg.gain;
         move_p_ff <= move_ff;
         dir_p_ff  <= dir_ff;
      end
   end

   assign scaled = prod_ff[28:4];

   always_comb begin
      steps     = 16'd0;
      direction = 1'b0;
      if (move_p_ff) begin
         steps     = (scaled > {9'd0, cfg.limit}) ? cfg.limit : scaled[15:0];
         direction = dir_p_ff;
      end
   end

endmodule
